// ===== hdl/functional_graph_kth_successor_top_assert.svh =====
// Assertion macros shared by the jump table RTL.
// FGKS_ASSERT checks a property outside reset.
// FGKS_ASSERT_RST checks a property that also covers the reset cycles.
`ifndef FUNCTIONAL_GRAPH_KTH_SUCCESSOR_TOP_ASSERT_SVH
`define FUNCTIONAL_GRAPH_KTH_SUCCESSOR_TOP_ASSERT_SVH
`ifndef SYNTH
`define FGKS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FGKS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FGKS_ASSERT(label, prop, msg)
`define FGKS_ASSERT_RST(label, prop, msg)
`endif
`endif

// ===== hdl/fgks_pkg.sv =====
package fgks_pkg;

  // Graph and table geometry
  localparam int MAX_NODES   = 1024;
  localparam int STEP_LEVELS = 31;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int LEVEL_W     = $clog2(STEP_LEVELS);
  localparam int ADDR_W      = LEVEL_W + NODE_W;
  localparam int MEM_DEPTH   = STEP_LEVELS * MAX_NODES;
  localparam int STEPS_W     = 31;
  localparam int COUNT_W     = 11;
  localparam int OPCODE_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_NODES);
  localparam logic [COUNT_W-1:0] SPAN_MAX    = COUNT_W'(MAX_NODES);
  localparam logic [LEVEL_W-1:0] LEVEL_TOP   = LEVEL_W'(STEP_LEVELS - 1);

  // Operation codes; the remaining code is a no-op
  localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_BUILD = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

  // One accepted command
  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [NODE_W-1:0]   node;
    logic [NODE_W-1:0]   successor;
    logic [STEPS_W-1:0]  steps;
  } fgks_cmd_t;

  // Core status toward the channel logic
  typedef struct packed {
    logic ready;
    logic res_valid;
  } fgks_stat_t;

endpackage

// ===== hdl/fgks_core.sv =====
`include "functional_graph_kth_successor_top_assert.svh"

module fgks_core
  import fgks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  fgks_cmd_t           cmd,
  input  logic [COUNT_W-1:0]  node_count,
  input  logic                res_take,
  output fgks_stat_t          stat,
  output logic [NODE_W-1:0]   res_end_node
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_BADDR,
    S_BMID,
    S_BWR,
    S_QRUN,
    S_QDONE
  } state_t;

  state_t               state_r, state_nxt;
  logic [LEVEL_W-1:0]   lv_r, lv_nxt;
  logic [NODE_W-1:0]    j_r, j_nxt;
  logic [NODE_W-1:0]    cur_r, cur_nxt;
  logic                 pend_r, pend_nxt;
  logic [STEPS_W-1:0]   steps_r, steps_nxt;

  // Jump table: level in the upper address bits, node in the lower
  logic [NODE_W-1:0]    mem [MEM_DEPTH];
  logic [NODE_W-1:0]    rdata_r;
  logic                 mem_we, mem_re;
  logic [ADDR_W-1:0]    waddr, raddr;
  logic [NODE_W-1:0]    wdata;

  logic [COUNT_W-1:0]   span;
  logic                 j_last;
  logic [NODE_W-1:0]    cur_eff;
  logic [LEVEL_W-1:0]   lv_below;

  // Clamp the build span to the table size
  assign span     = (node_count > SPAN_MAX) ? SPAN_MAX : node_count;
  assign j_last   = ({1'b0, j_r} == (span - COUNT_W'(1)));
  assign lv_below = lv_r - LEVEL_W'(1);
  // Current node: fresh read data when the last level hop issued a read
  assign cur_eff  = pend_r ? rdata_r : cur_r;

  // Sequencer next state and memory control
  always_comb begin
    state_nxt = state_r;
    lv_nxt    = lv_r;
    j_nxt     = j_r;
    cur_nxt   = cur_r;
    pend_nxt  = pend_r;
    steps_nxt = steps_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    waddr     = '0;
    raddr     = '0;
    wdata     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          case (cmd.opcode)
            OP_LOAD: begin
              mem_we = 1'b1;
              waddr  = {LEVEL_W'(0), cmd.node};
              wdata  = cmd.successor;
            end
            OP_BUILD: begin
              if (span != '0) begin
                lv_nxt    = LEVEL_W'(1);
                j_nxt     = '0;
                state_nxt = S_BADDR;
              end
            end
            OP_QUERY: begin
              cur_nxt   = cmd.node;
              pend_nxt  = 1'b0;
              steps_nxt = cmd.steps;
              lv_nxt    = LEVEL_TOP;
              state_nxt = S_QRUN;
            end
            default: begin
            end
          endcase
        end
      end
      S_BADDR: begin
        // Fetch the first hop of entry j
        mem_re    = 1'b1;
        raddr     = {lv_below, j_r};
        state_nxt = S_BMID;
      end
      S_BMID: begin
        // Fetch the second hop through the midpoint
        mem_re    = 1'b1;
        raddr     = {lv_below, rdata_r};
        state_nxt = S_BWR;
      end
      S_BWR: begin
        mem_we = 1'b1;
        waddr  = {lv_r, j_r};
        wdata  = rdata_r;
        if (!j_last) begin
          // Overlap the next entry's first hop with this write
          j_nxt     = j_r + NODE_W'(1);
          mem_re    = 1'b1;
          raddr     = {lv_below, j_r + NODE_W'(1)};
          state_nxt = S_BMID;
        end else if (lv_r == LEVEL_TOP) begin
          state_nxt = S_IDLE;
        end else begin
          lv_nxt    = lv_r + LEVEL_W'(1);
          j_nxt     = '0;
          state_nxt = S_BADDR;
        end
      end
      S_QRUN: begin
        // Hop through this level when its step bit is set
        cur_nxt  = cur_eff;
        pend_nxt = steps_r[lv_r];
        if (steps_r[lv_r]) begin
          mem_re = 1'b1;
          raddr  = {lv_r, cur_eff};
        end
        if (lv_r == '0) begin
          state_nxt = S_QDONE;
        end else begin
          lv_nxt = lv_below;
        end
      end
      S_QDONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and working registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    lv_r    <= lv_nxt;
    j_r     <= j_nxt;
    cur_r   <= cur_nxt;
    steps_r <= steps_nxt;
  end

  // Jump table port: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign stat.ready     = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_QDONE);
  assign res_end_node   = cur_eff;

  `FGKS_ASSERT(a_query_no_write, ((state_r == S_QRUN || state_r == S_QDONE) |-> !mem_we), "table written during a query")
  `FGKS_ASSERT(a_result_holds, ((state_r == S_QDONE && !res_take) |=> (state_r == S_QDONE && $stable(res_end_node))), "pending result changed")
  `FGKS_ASSERT(a_build_bounds, ((state_r == S_BWR) |-> (lv_r != '0 && ({1'b0, j_r} < span))), "build write out of range")

endmodule

// ===== hdl/functional_graph_kth_successor_top.sv =====
// K-th successor engine on a functional graph using a binary lifting jump table of
// 31 levels by 1024 nodes, held in one single-port-read, single-port-write memory.
// A load writes level 0 in the cycle it is accepted. A query walks the levels from
// the top bit of steps down, one level per cycle with the read data fed straight
// back as the next address; the next command is accepted only after the query's
// result moves to the output register, which waits while out_stall holds it full.
// A build fills levels 1 to 30 for min(node_count, 1024) nodes with two dependent
// table reads per entry and gives no result. Queries are meaningful only after a
// build over every node they can reach. cfg_wdata writes node_count, which resets
// to 1024 and must only be written while the block is idle.
`include "functional_graph_kth_successor_top_assert.svh"

module functional_graph_kth_successor_top
  import fgks_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [COUNT_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [NODE_W-1:0]   in_node,
  input  logic [NODE_W-1:0]   in_successor,
  input  logic [STEPS_W-1:0]  in_steps,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [NODE_W-1:0]   out_end_node
);

  logic [COUNT_W-1:0] node_count_r;
  logic               out_valid_r;
  logic [NODE_W-1:0]  out_end_node_r;
  fgks_cmd_t          cmd;
  fgks_stat_t         stat;
  logic               start;
  logic               res_take;
  logic [NODE_W-1:0]  res_end_node;

  // Pack the input transfer
  assign cmd.opcode    = in_opcode;
  assign cmd.node      = in_node;
  assign cmd.successor = in_successor;
  assign cmd.steps     = in_steps;

  assign in_stall = !stat.ready;
  assign start    = in_valid && stat.ready;
  // Move the result into the output slot when it is free or draining
  assign res_take = stat.res_valid && (!out_valid_r || !out_stall);

  fgks_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .cmd          (cmd),
    .node_count   (node_count_r),
    .res_take     (res_take),
    .stat         (stat),
    .res_end_node (res_end_node)
  );

  // Hold the node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= COUNT_RESET;
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Output register: load on take, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (res_take) begin
      out_end_node_r <= res_end_node;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_end_node = out_end_node_r;

  `FGKS_ASSERT_RST(a_count_reset, (!rst_n |=> (node_count_r == COUNT_RESET)), "node count not reset")
  `FGKS_ASSERT(a_query_blocks, ((in_valid && !in_stall && in_opcode == OP_QUERY) |=> in_stall), "input not held off after a query")
  `FGKS_ASSERT(a_out_from_core, ($rose(out_valid_r) |-> $past(res_take)), "output valid without a core result")

endmodule
